// ===== rtl/cprp_pkg.sv =====
// ----------------------------------------------------------------------------
// cprp_pkg
// Shared constants and types for the code point record parser.
// ----------------------------------------------------------------------------
package cprp_pkg;

    localparam logic [21:0] CODE_MAX = 22'h10FFFF;
    localparam logic [21:0] CODE_CAP = 22'h110000;
    localparam logic [63:0] FIRST_TAG = 64'h2C2046697273743E;
    localparam logic [55:0] LAST_TAG = 56'h2C204C6173743E;
    localparam logic [15:0] LEN_CAP = 16'hFFFF;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FIELDS = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_PAIR = 2'd3;

    typedef enum logic [5:0] {
        PH_NONE = 6'b000001,
        PH_LOW = 6'b000010,
        PH_DOT1 = 6'b000100,
        PH_DOT2 = 6'b001000,
        PH_HIGH = 6'b010000,
        PH_BAD = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        RS_SINGLE = 2'd0,
        RS_SPAN = 2'd1,
        RS_BAD = 2'd2
    } rstat_t;

    typedef struct packed {
        logic [20:0] first_code;
        logic [20:0] last_code;
        logic [4:0] field_count;
        logic [1:0] status;
    } result_t;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39)
            v = {1'b0, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            v = 5'(b[3:0]) + 5'd9;
        else
            v = 5'd16;
        return v;
    endfunction

    function automatic logic [21:0] push_digit(input logic [21:0] acc, input logic [3:0] d);
        logic [25:0] t;
        if (acc > CODE_MAX)
            return CODE_CAP;
        t = {acc, d};
        return (t > 26'(CODE_MAX)) ? CODE_CAP : t[21:0];
    endfunction

endpackage

// ===== rtl/cprp_name_ram.sv =====
// ----------------------------------------------------------------------------
// cprp_name_ram
// Name store: one write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cprp_name_ram #(
    parameter int DEPTH = 128,
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/codepoint_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// codepoint_record_parser_unit
// Code point record parser: strips comments, splits lines on ';', decodes
// the code point or range of field 0 and pairs First/Last named ranges.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one file byte per transaction, tlast on the final byte.
//  m_axis carries one record per line that holds a record or on a fault.
//  cfg writes unicode_data_mode; the user must do so only while the block is idle, which the block does not enforce.
//  Throughput: one byte per cycle while the receiver does not stall. A byte
//  is decoded in the decode stage, when the name store read issued at
//  acceptance returns; a one-entry output register holds the record. The
//  name store has one write port and one read port.
//  If the receiver stalls, input is held off once the output register is
//  full and any byte waits in the decode stage.
//  Reset clears all control state; the name store needs no clearing.
//  A fault emits one error record and then every further byte is consumed
//  with no output until reset.
// ----------------------------------------------------------------------------
module codepoint_record_parser_unit #(
    parameter int FIELD_LIMIT = 16,
    parameter int NAME_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // first_code, last_code, field_count
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data        // unicode_data_mode
);
    import cprp_pkg::*;

    localparam int AW = $clog2(NAME_BYTES);

    // decode stage registers
    logic        d_v_reg;
    logic [7:0]  d_b_reg;
    logic        d_l_reg;
    logic        mode_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  fidx_reg, fidx_next;
    logic        fopen_reg, fopen_next, fcont_reg, fcont_next;
    logic        cmt_reg, cmt_next, f0ne_reg, f0ne_next, sp_reg, sp_next;
    logic [21:0] lo_reg, lo_next, hi_reg, hi_next;
    logic        lt_reg, lt_next;
    logic [15:0] raw_reg, raw_next, trim_reg, trim_next;
    logic [63:0] sw_reg, sw_next, tw_reg, tw_next;
    logic [8:0]  nlen_reg, nlen_next, mpos_reg, mpos_next;
    logic        live_reg, live_next;
    logic [20:0] pf_reg, pf_next;
    logic [4:0]  pc_reg, pc_next;
    rstat_t      ps_reg, ps_next;
    logic        pp_reg, pp_next, halt_reg, halt_next;

    logic        o_v_reg;
    result_t     o_reg;
    logic        emit;
    result_t     res;

    // name store: write address and compare position track raw length
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_rdata;
    logic [15:0] raw_at_accept_reg, raw_pred;

    logic stall;
    assign stall = d_v_reg && o_v_reg && !m_axis_tready;
    assign s_axis_tready = !stall;
    assign cfg_ready = 1'b1;

    // predicted raw length index for the byte being accepted: j = raw+1-2
    assign raw_pred = (d_v_reg) ? raw_next : raw_reg;
    assign ram_raddr = AW'(raw_pred - 16'd1);

    cprp_name_ram #(.DEPTH(NAME_BYTES), .AW(AW)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(d_b_reg),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_comb
    begin
        logic [7:0]  b;
        logic [4:0]  d;
        logic        go;
        logic [4:0]  cur;
        logic [15:0] j;
        logic [21:0] rlo, rhi;
        rstat_t      st;
        logic        ok;
        logic        fault;
        logic        eol;
        logic        rec;
        logic [15:0] nl;

        b = d_b_reg;
        phase_next = phase_reg; fidx_next = fidx_reg; fopen_next = fopen_reg;
        fcont_next = fcont_reg; cmt_next = cmt_reg; f0ne_next = f0ne_reg;
        sp_next = sp_reg; lo_next = lo_reg; hi_next = hi_reg; lt_next = lt_reg;
        raw_next = raw_reg; trim_next = trim_reg; sw_next = sw_reg; tw_next = tw_reg;
        nlen_next = nlen_reg; mpos_next = mpos_reg; live_next = live_reg;
        pf_next = pf_reg; pc_next = pc_reg; ps_next = ps_reg; pp_next = pp_reg;
        halt_next = halt_reg;
        emit = 1'b0; res = '0; ram_we = 1'b0; ram_waddr = '0;
        fault = 1'b0; j = '0; d = '0; cur = '0;
        rlo = '0; rhi = '0; st = RS_BAD; ok = 1'b0; nl = '0; rec = 1'b0;
        go = d_v_reg && !halt_reg && !stall;
        eol = (b == CH_NL) || d_l_reg;

        if (go && b != CH_NL && !cmt_reg)
        begin
            if (b == CH_HASH)
                cmt_next = 1'b1;
            else
            begin
                if (!fopen_reg)
                begin
                    if (fidx_reg >= 5'(FIELD_LIMIT))
                    begin
                        fault = 1'b1;
                        emit = 1'b1;
                        res.status = ST_FIELDS;
                        halt_next = 1'b1;
                    end
                    fidx_next = fidx_reg + 5'd1;
                    fopen_next = 1'b1;
                    fcont_next = 1'b0;
                end
                if (!fault)
                begin
                    cur = fidx_next - 5'd1;
                    if (b == CH_SEMI)
                        fopen_next = 1'b0;
                    else if (!(b == CH_SPACE && !fcont_next))
                    begin
                        fcont_next = 1'b1;
                        if (cur == 5'd0)
                        begin
                            if (b == CH_SPACE)
                                sp_next = 1'b1;
                            else
                            begin
                                f0ne_next = 1'b1;
                                if (sp_reg)
                                    phase_next = PH_BAD;
                                d = hex_value(b);
                                if (d < 5'd16)
                                begin
                                    if (phase_next == PH_NONE || phase_next == PH_LOW)
                                    begin
                                        phase_next = PH_LOW;
                                        lo_next = push_digit(lo_reg, d[3:0]);
                                    end
                                    else if (phase_next == PH_DOT2 || phase_next == PH_HIGH)
                                    begin
                                        phase_next = PH_HIGH;
                                        hi_next = push_digit(hi_reg, d[3:0]);
                                    end
                                    else
                                        phase_next = PH_BAD;
                                end
                                else if (b == CH_DOT && phase_next == PH_LOW)
                                    phase_next = PH_DOT1;
                                else if (b == CH_DOT && phase_next == PH_DOT1)
                                    phase_next = PH_DOT2;
                                else
                                    phase_next = PH_BAD;
                            end
                        end
                        else if (cur == 5'd1)
                        begin
                            if (raw_reg < LEN_CAP)
                                raw_next = raw_reg + 16'd1;
                            if (raw_next == 16'd1)
                                lt_next = (b == CH_LT);
                            else
                            begin
                                j = raw_next - 16'd2;
                                if (j < 16'(NAME_BYTES))
                                begin
                                    if (!pp_reg)
                                    begin
                                        ram_we = 1'b1;
                                        ram_waddr = AW'(j);
                                    end
                                    else if (live_reg)
                                    begin
                                        if (ram_rdata == b && raw_at_accept_reg == raw_reg)
                                            mpos_next = mpos_reg + 9'd1;
                                        else
                                            live_next = 1'b0;
                                    end
                                end
                            end
                            sw_next = {sw_reg[55:0], b};
                            if (b != CH_SPACE)
                            begin
                                trim_next = raw_next;
                                tw_next = sw_next;
                            end
                        end
                    end
                end
            end
        end

        if (go && !fault && eol)
        begin
            rec = f0ne_next && fidx_next >= 5'd2;
            if (phase_next == PH_LOW && lo_next <= CODE_MAX)
            begin
                rlo = lo_next; rhi = lo_next; st = RS_SINGLE;
            end
            else if (phase_next == PH_HIGH && lo_next <= CODE_MAX &&
                     hi_next <= CODE_MAX && hi_next > lo_next)
            begin
                rlo = lo_next; rhi = hi_next; st = RS_SPAN;
            end
            if (rec)
            begin
                if (pp_reg)
                begin
                    pp_next = 1'b0;
                    ok = fidx_next == pc_reg && lt_next &&
                         trim_next == 16'(nlen_reg) + 16'd8 &&
                         tw_next[55:0] == LAST_TAG && mpos_next >= nlen_reg;
                    emit = 1'b1;
                    if (!ok)
                    begin
                        res.status = ST_PAIR; halt_next = 1'b1;
                    end
                    else if (ps_reg == RS_BAD || st == RS_BAD)
                    begin
                        res.status = ST_RANGE; halt_next = 1'b1;
                    end
                    else if (ps_reg != RS_SINGLE || st != RS_SINGLE ||
                             22'(pf_reg) >= rhi)
                    begin
                        res.status = ST_PAIR; halt_next = 1'b1;
                    end
                    else
                    begin
                        res.first_code = pf_reg;
                        res.last_code = rhi[20:0];
                        res.field_count = fidx_next;
                        res.status = ST_OK;
                    end
                end
                else if (mode_reg && lt_next && trim_next > 16'd9 && tw_next == FIRST_TAG)
                begin
                    nl = trim_next - 16'd9;
                    if (nl > 16'(NAME_BYTES))
                    begin
                        emit = 1'b1; res.status = ST_PAIR; halt_next = 1'b1;
                    end
                    else
                    begin
                        nlen_next = nl[8:0];
                        pf_next = rlo[20:0];
                        ps_next = st;
                        pc_next = fidx_next;
                        pp_next = 1'b1;
                    end
                end
                else if (st == RS_BAD)
                begin
                    emit = 1'b1; res.status = ST_RANGE; halt_next = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    res.first_code = rlo[20:0];
                    res.last_code = rhi[20:0];
                    res.field_count = fidx_next;
                end
            end
            if (!halt_next && d_l_reg && pp_next)
            begin
                emit = 1'b1;
                res = '0;
                res.status = ST_PAIR;
                halt_next = 1'b1;
            end
            phase_next = PH_NONE; fidx_next = '0; fopen_next = 1'b0;
            fcont_next = 1'b0; cmt_next = 1'b0; f0ne_next = 1'b0; sp_next = 1'b0;
            lo_next = '0; hi_next = '0; lt_next = 1'b0; raw_next = '0;
            trim_next = '0; sw_next = '0; tw_next = '0; mpos_next = '0;
            live_next = 1'b1;
            if (d_l_reg)
                pp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0; mode_reg <= 1'b0; o_v_reg <= 1'b0;
            phase_reg <= PH_NONE; fidx_reg <= '0; fopen_reg <= 1'b0;
            fcont_reg <= 1'b0; cmt_reg <= 1'b0; f0ne_reg <= 1'b0; sp_reg <= 1'b0;
            lo_reg <= '0; hi_reg <= '0; lt_reg <= 1'b0; raw_reg <= '0;
            trim_reg <= '0; sw_reg <= '0; tw_reg <= '0; nlen_reg <= '0;
            mpos_reg <= '0; live_reg <= 1'b1; pf_reg <= '0; pc_reg <= '0;
            ps_reg <= RS_SINGLE; pp_reg <= 1'b0; halt_reg <= 1'b0;
            raw_at_accept_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (!stall)
            begin
                d_v_reg <= s_axis_tvalid;
                raw_at_accept_reg <= raw_pred;
            end
            phase_reg <= phase_next; fidx_reg <= fidx_next; fopen_reg <= fopen_next;
            fcont_reg <= fcont_next; cmt_reg <= cmt_next; f0ne_reg <= f0ne_next;
            sp_reg <= sp_next; lo_reg <= lo_next; hi_reg <= hi_next; lt_reg <= lt_next;
            raw_reg <= raw_next; trim_reg <= trim_next; sw_reg <= sw_next;
            tw_reg <= tw_next; nlen_reg <= nlen_next; mpos_reg <= mpos_next;
            live_reg <= live_next; pf_reg <= pf_next; pc_reg <= pc_next;
            ps_reg <= ps_next; pp_reg <= pp_next; halt_reg <= halt_next;
            if (emit)
                o_v_reg <= 1'b1;
            else if (m_axis_tready)
                o_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            d_b_reg <= s_axis_tdata;
            d_l_reg <= s_axis_tlast;
        end
        if (emit)
            o_reg <= res;
    end

    assign m_axis_tvalid = o_v_reg;
    assign m_axis_tdata = {1'b0, o_reg.field_count, o_reg.last_code, o_reg.first_code};
    assign m_axis_tuser = o_reg.status;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg) else $error("halt cleared");
    a_no_emit_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> !emit) else $error("emit while halted");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && !m_axis_tready) |-> !emit) else $error("output overrun");
`endif
endmodule

// ===== tb/codepoint_record_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// codepoint_record_parser_unit_tb
// Streams text data files byte by byte into the parser and checks each
// record against a cycle-free model of the line parsing. The run goes
// through directed lines, random well-formed files in both modes, and a
// single closing fault, since a fault halts the block until reset.
// ----------------------------------------------------------------------------
module codepoint_record_parser_unit_tb;

    import cprp_pkg::*;

    localparam int FIELD_MAX = 16;
    localparam int NAME_MAX = 128;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] b;
        logic       l;
    } file_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    file_byte_t  pending_bytes[$];
    result_t     expected_records[$];
    int          errors;
    int          idle_cycles;
    logic        in_took;
    logic        no_idle;
    logic        hold_req;
    int          hold_left;

    // parser model state
    logic        data_mode;
    phase_t      phase;
    int          fidx;
    bit          fopen, fcontent, in_comment, f0_seen, space_seen;
    logic [21:0] low_acc, high_acc;
    bit          name_lt;
    int          raw_len, trim_len;
    logic [63:0] tail_win, trim_win;
    logic [7:0]  names[NAME_MAX];
    int          name_len, match_pos;
    bit          match_ok;
    logic [20:0] held_first;
    int          held_count;
    rstat_t      held_range;
    bit          pair_open;
    bit          stopped;

    codepoint_record_parser_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [20:0] got,
                                   input logic [20:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // ---------------- parser model ----------------

    function automatic void clear_line();
        phase = PH_NONE;
        fidx = 0;
        fopen = 0;
        fcontent = 0;
        in_comment = 0;
        f0_seen = 0;
        space_seen = 0;
        low_acc = '0;
        high_acc = '0;
        name_lt = 0;
        raw_len = 0;
        trim_len = 0;
        tail_win = '0;
        trim_win = '0;
        match_pos = 0;
        match_ok = 1;
    endfunction

    function automatic void add_record(logic [20:0] first, logic [20:0] last,
                                       int count, logic [1:0] st);
        result_t r;
        r.first_code = first;
        r.last_code = last;
        r.field_count = 5'(count);
        r.status = st;
        expected_records.push_back(r);
    endfunction

    function automatic void halt_with(logic [1:0] st);
        stopped = 1;
        add_record('0, '0, 0, st);
    endfunction

    function automatic logic [21:0] shift_digit(logic [21:0] acc, logic [3:0] d);
        logic [25:0] t;
        t = {acc, d};
        if (acc > CODE_MAX || t > 26'(CODE_MAX))
            return CODE_CAP;
        return t[21:0];
    endfunction

    function automatic void range_byte(logic [7:0] b);
        logic [3:0] d;
        bit is_hex;
        if (b == CH_SPACE)
        begin
            space_seen = 1;
            return;
        end
        f0_seen = 1;
        if (space_seen)
            phase = PH_BAD;
        is_hex = 1;
        if (b >= "0" && b <= "9")
            d = b[3:0];
        else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
            d = b[3:0] + 4'd9;
        else
            is_hex = 0;
        if (is_hex)
        begin
            if (phase == PH_NONE || phase == PH_LOW)
            begin
                phase = PH_LOW;
                low_acc = shift_digit(low_acc, d);
            end
            else if (phase == PH_DOT2 || phase == PH_HIGH)
            begin
                phase = PH_HIGH;
                high_acc = shift_digit(high_acc, d);
            end
            else
                phase = PH_BAD;
        end
        else if (b == CH_DOT && phase == PH_LOW)
            phase = PH_DOT1;
        else if (b == CH_DOT && phase == PH_DOT1)
            phase = PH_DOT2;
        else
            phase = PH_BAD;
    endfunction

    function automatic void name_byte(logic [7:0] b);
        int j;
        if (raw_len < 65535)
            raw_len++;
        if (raw_len == 1)
            name_lt = (b == CH_LT);
        else
        begin
            j = raw_len - 2;
            if (j < NAME_MAX)
            begin
                if (!pair_open)
                    names[j] = b;
                else if (match_ok)
                begin
                    if (names[j] == b)
                        match_pos++;
                    else
                        match_ok = 0;
                end
            end
        end
        tail_win = {tail_win[55:0], b};
        if (b != CH_SPACE)
        begin
            trim_len = raw_len;
            trim_win = tail_win;
        end
    endfunction

    function automatic void close_record();
        logic [20:0] lo, hi;
        rstat_t rs;
        lo = '0;
        hi = '0;
        rs = RS_BAD;
        if (phase == PH_LOW && low_acc <= CODE_MAX)
        begin
            lo = low_acc[20:0];
            hi = low_acc[20:0];
            rs = RS_SINGLE;
        end
        else if (phase == PH_HIGH && low_acc <= CODE_MAX && high_acc <= CODE_MAX
                 && high_acc > low_acc)
        begin
            lo = low_acc[20:0];
            hi = high_acc[20:0];
            rs = RS_SPAN;
        end
        if (pair_open)
        begin
            pair_open = 0;
            if (!(fidx == held_count && name_lt && trim_len == name_len + 8
                  && trim_win[55:0] == LAST_TAG && match_pos >= name_len))
                halt_with(ST_PAIR);
            else if (held_range == RS_BAD || rs == RS_BAD)
                halt_with(ST_RANGE);
            else if (held_range != RS_SINGLE || rs != RS_SINGLE || held_first >= hi)
                halt_with(ST_PAIR);
            else
                add_record(held_first, hi, fidx, ST_OK);
        end
        else if (data_mode && name_lt && trim_len > 9 && trim_win == FIRST_TAG)
        begin
            if (trim_len - 9 > NAME_MAX)
                halt_with(ST_PAIR);
            else
            begin
                name_len = trim_len - 9;
                held_first = lo;
                held_range = rs;
                held_count = fidx;
                pair_open = 1;
            end
        end
        else if (rs == RS_BAD)
            halt_with(ST_RANGE);
        else
            add_record(lo, hi, fidx, ST_OK);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic eof);
        if (stopped)
            return;
        if (b != CH_NL && !in_comment)
        begin
            if (b == CH_HASH)
                in_comment = 1;
            else
            begin
                if (!fopen)
                begin
                    if (fidx >= FIELD_MAX)
                    begin
                        halt_with(ST_FIELDS);
                        return;
                    end
                    fidx++;
                    fopen = 1;
                    fcontent = 0;
                end
                if (b == CH_SEMI)
                    fopen = 0;
                else if (!(b == CH_SPACE && !fcontent))
                begin
                    fcontent = 1;
                    if (fidx == 1)
                        range_byte(b);
                    else if (fidx == 2)
                        name_byte(b);
                end
            end
        end
        if (b == CH_NL || eof)
        begin
            if (f0_seen && fidx >= 2)
                close_record();
            if (!stopped && eof && pair_open)
                halt_with(ST_PAIR);
            clear_line();
            if (eof)
                pair_open = 0;
        end
    endfunction

    // ---------------- file text generation ----------------

    function automatic void put(logic [7:0] b);
        file_byte_t x;
        x.b = b;
        x.l = 1'b0;
        pending_bytes.push_back(x);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put(s.getc(i));
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_HASH || b == CH_SEMI || b == CH_NL);
        return b;
    endfunction

    function automatic void put_text(int n);
        repeat (n)
            put(text_char());
    endfunction

    function automatic void put_pad();
        repeat ($urandom_range(0, 2))
            put(CH_SPACE);
    endfunction

    function automatic void put_hex(int v);
        case ($urandom_range(0, 2))
            0: put_str($sformatf("%0X", v));
            1: put_str($sformatf("%0x", v));
            default: put_str($sformatf("%06X", v));
        endcase
    endfunction

    function automatic int pick_code();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 'h10FFFF;
            2: return $urandom_range(0, 'hFF);
            default: return $urandom_range(0, 'h10FFFF);
        endcase
    endfunction

    function automatic void end_line(bit eof);
        if ($urandom_range(0, 3) == 0)
        begin
            put(CH_HASH);
            repeat ($urandom_range(0, 8))
            begin
                logic [7:0] b;
                b = 8'($urandom_range(0, 255));
                put(b == CH_NL ? CH_SPACE : b);
            end
        end
        if (eof && $urandom_range(0, 1))
            pending_bytes[$].l = 1'b1;
        else
        begin
            put(CH_NL);
            pending_bytes[$].l = eof;
        end
    endfunction

    function automatic void put_fields(int from, int count);
        for (int i = from; i < count; i++)
        begin
            put(CH_SEMI);
            put_pad();
            put_text($urandom_range(0, 6));
        end
    endfunction

    function automatic void record_line(int count, bit eof);
        int lo, hi;
        lo = pick_code();
        put_pad();
        if (lo < 'h10FFFF && $urandom_range(0, 2) == 0)
        begin
            hi = $urandom_range(lo + 1, 'h10FFFF);
            put_hex(lo);
            put_str("..");
            put_hex(hi);
        end
        else
            put_hex(lo);
        put_pad();
        put_fields(1, count);
        end_line(eof);
    endfunction

    function automatic void skipped_line();
        case ($urandom_range(0, 4))
            0: ;
            1: put_str(";x;y");
            2: put_str("   ;abc");
            3: put_hex(pick_code());
            default:
            begin
                put_hex(pick_code());
                put(CH_SEMI);
            end
        endcase
        end_line(0);
    endfunction

    function automatic void pair_lines(int nlen, int count, bit tamper, bit eof_open);
        logic [7:0] nm[$];
        int lo, hi;
        repeat (nlen)
            nm.push_back(text_char());
        lo = $urandom_range(0, 'h10FFFE);
        hi = $urandom_range(lo + 1, 'h10FFFF);
        put_hex(lo);
        put(CH_SEMI);
        put_pad();
        put(CH_LT);
        foreach (nm[i])
            put(nm[i]);
        put_str(", First>");
        put_pad();
        put_fields(2, count);
        put(CH_NL);
        if (eof_open)
        begin
            pending_bytes[$].l = 1'b1;
            return;
        end
        repeat ($urandom_range(0, 2))
            skipped_line();
        put_hex(hi);
        put(CH_SEMI);
        put(CH_LT);
        foreach (nm[i])
            put(tamper && i == 0 ? ~nm[i] & 8'h7F | 8'h40 : nm[i]);
        put_str(", Last>");
        put_pad();
        put_fields(2, count);
        end_line(0);
    endfunction

    function automatic void random_line();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            record_line($urandom_range(2, 15), $urandom_range(0, 19) == 0);
        else if (k < 75)
            pair_lines($urandom_range(1, 20), $urandom_range(2, 6), 0, 0);
        else
            skipped_line();
    endfunction

    // ---------------- driver, monitor, watchdog ----------------

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else if (!s_axis_tvalid || in_took)
        begin
            if (pending_bytes.size() > 0 && (no_idle || $urandom_range(0, 99) >= 36))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes[0].b;
                s_axis_tlast <= pending_bytes[0].l;
                pending_bytes.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_idle || $urandom_range(0, 99) >= 36;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        in_took <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            parse_byte(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_records.size() == 0)
                report_mismatch("unexpected record", m_axis_tdata[20:0], 21'd0);
            else
            begin
                want = expected_records.pop_front();
                if (m_axis_tdata[20:0] != want.first_code)
                    report_mismatch("first_code", m_axis_tdata[20:0], want.first_code);
                if (m_axis_tdata[41:21] != want.last_code)
                    report_mismatch("last_code", m_axis_tdata[41:21], want.last_code);
                if (m_axis_tdata[46:42] != want.field_count)
                    report_mismatch("field_count", 21'(m_axis_tdata[46:42]),
                                    21'(want.field_count));
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 21'(m_axis_tuser), 21'(want.status));
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    task automatic drain();
        do
            @(posedge clk);
        while (pending_bytes.size() > 0 || s_axis_tvalid || expected_records.size() > 0);
        repeat (6)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = m;
        do
            @(posedge clk);
        while (!cfg_ready);
        data_mode = m;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        in_took = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        data_mode = 1'b0;
        foreach (names[i])
            names[i] = '0;
        name_len = 0;
        held_first = '0;
        held_count = 0;
        held_range = RS_SINGLE;
        pair_open = 0;
        stopped = 0;
        clear_line();
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // long name field outside data mode
        set_mode(1'b0);
        put_str("0041;<");
        repeat (20)
            put(8'h41 + 8'($urandom_range(0, 25)));
        put(CH_NL);
        put_str("0;a\n10FFFF;b\n0..10ffff;c\n  abc ; d\n12..13;\r;");
        put(8'h00);
        put(8'hFF);
        put(CH_NL);
        put_str("# comment only\n\n;x;y\n1234\n5;\n");
        put_str("1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16\n");
        put_str("20;<Ab, First>;x\n21;<Ab, Last>;x\n");
        put_str("30;z");
        pending_bytes[$].l = 1'b1;
        drain();

        set_mode(1'b1);
        pair_lines(NAME_MAX, 3, 0, 0);
        pair_lines(1, 2, 0, 0);
        put_str("40;<q, First>\n;n;m\n# c\n41;<q, Last>\n");
        put_str("50..60;x\n");
        pending_bytes[$].l = 1'b1;
        drain();

        for (int p = 0; p < 6; p++)
        begin
            int goal;
            set_mode(p == 0 ? 1'b0 : p == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            if (p == 2)
                hold_req = 1'b1;
            no_idle = (p == 3);
            goal = (p == 2 || p == 3) ? 90 : 15;
            while (goal > 0)
            begin
                int prev_size;
                prev_size = pending_bytes.size();
                random_line();
                goal -= pending_bytes.size() - prev_size;
            end
            drain();
            no_idle = 1'b0;
        end

        // a fault halts the block until reset, so only one comes at the end
        set_mode(1'b1);
        case ($urandom_range(0, 4))
            0: put_str("1;a;a;a;a;a;a;a;a;a;a;a;a;a;a;a;a\n");
            1:
            begin
                case ($urandom_range(0, 3))
                    0: put_str("12 34;x\n");
                    1: put_str("1.2;x\n");
                    2: put_str("110000;x\n");
                    default: put_str("5..3;x\n");
                endcase
            end
            2: pair_lines(5, 2, 1, 0);
            3: pair_lines(4, 2, 0, 1);
            default: pair_lines(NAME_MAX + 1, 2, 0, 0);
        endcase
        put_text(20);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
